@@ src/clip_rect_stack_engine_assert.svh @@
// Assertion macros for the clip rectangle stack engine.
`ifndef CLIP_RECT_STACK_ENGINE_ASSERT_SVH
`define CLIP_RECT_STACK_ENGINE_ASSERT_SVH

// same-cycle implication
`define CRSE_AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clip rect stack engine: check failed");

// next-cycle implication
`define CRSE_AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("clip rect stack engine: check failed");

`endif

@@ src/crs_pkg.sv @@
package crs_pkg;

    localparam int COORD_BITS = 16;
    localparam int MW         = 18;  // mapped rectangle
    localparam int QW         = 17;  // edge sums
    localparam int CW         = 20;  // intersection arithmetic

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [2:0] CFG_WIN_W = 3'd0;
    localparam logic [2:0] CFG_WIN_H = 3'd1;
    localparam logic [2:0] CFG_SCR_W = 3'd2;
    localparam logic [2:0] CFG_SCR_H = 3'd3;
    localparam logic [2:0] CFG_OFF_X = 3'd4;
    localparam logic [2:0] CFG_OFF_Y = 3'd5;
    localparam logic [2:0] CFG_ROT   = 3'd6;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] size_w;
        logic signed [15:0] size_h;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               scissor_on;
        logic signed [15:0] scissor_x;
        logic signed [15:0] scissor_y;
        logic [14:0]        scissor_w;
        logic [14:0]        scissor_h;
        logic               clipping_on;
        logic               visible;
    } t_rsp;

    typedef struct packed {
        logic [13:0]        win_w;
        logic [13:0]        win_h;
        logic [13:0]        scr_w;
        logic [13:0]        scr_h;
        logic signed [14:0] off_x;
        logic signed [14:0] off_y;
        logic [1:0]         rot;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [COORD_BITS-2:0]        w;
        logic [COORD_BITS-2:0]        h;
    } t_scis;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } t_rect;

    typedef struct packed {
        t_scis scis;
        t_rect nat;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

    typedef struct packed {
        logic [1:0]         mode;
        t_rect              nat;
        logic signed [MW-1:0] mx;
        logic signed [MW-1:0] my;
        logic signed [MW-1:0] mw;
        logic signed [MW-1:0] mh;
        logic signed [QW-1:0] xe;
        logic signed [QW-1:0] ye;
        logic               q_pass;
    } t_stage;

endpackage

@@ src/crs_cell.sv @@
module crs_cell (
    input  logic           i_clk,
    input  crs_pkg::t_shift i_ctl,
    input  crs_pkg::t_entry i_above,
    input  crs_pkg::t_entry i_below,
    output crs_pkg::t_entry o_data
);
    import crs_pkg::*;

    t_entry r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_data <= i_above;
        end else if (i_ctl.pop) begin
            r_data <= i_below;
        end
    end

    assign o_data = r_data;

endmodule

@@ src/crs_map.sv @@
module crs_map (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  crs_pkg::t_req   i_req,
    input  crs_pkg::t_cfg   i_cfg,
    output logic            o_busy,
    output logic            o_vld,
    output crs_pkg::t_stage o_stg
);
    import crs_pkg::*;

    t_req   r_req;
    logic   r_vld1;
    t_stage r_stg;
    logic   r_vld2;
    t_stage n_stg;

    logic signed [MW-1:0] x, y, w, h, ww, wh, sw, sh, ox, oy;
    logic signed [MW-1:0] bw, bh, ax, ay, xe, ye;
    logic                 xo, yo, v_neg, v_edge;

    always_comb begin
        x  = MW'(r_req.pos_x);
        y  = MW'(r_req.pos_y);
        w  = MW'(r_req.size_w);
        h  = MW'(r_req.size_h);
        ww = MW'($signed({1'b0, i_cfg.win_w}));
        wh = MW'($signed({1'b0, i_cfg.win_h}));
        sw = MW'($signed({1'b0, i_cfg.scr_w}));
        sh = MW'($signed({1'b0, i_cfg.scr_h}));
        ox = MW'(i_cfg.off_x);
        oy = MW'(i_cfg.off_y);

        bw = (w == '0) ? sw - x : w;
        bh = (h == '0) ? sh - y : h;
        ax = ox + x;
        ay = oy + y;
        xe = x + w;
        ye = y + h;

        n_stg      = '0;
        n_stg.mode = r_req.mode;
        n_stg.nat  = '{x: r_req.pos_x, y: r_req.pos_y, w: r_req.size_w, h: r_req.size_h};
        n_stg.xe   = QW'(xe);
        n_stg.ye   = QW'(ye);

        unique case (i_cfg.rot)
            ROT_0: begin
                n_stg.mx = ax;
                n_stg.my = ay;
                n_stg.mw = bw;
                n_stg.mh = bh;
            end
            ROT_90: begin
                n_stg.mx = ww - ay - bh;
                n_stg.my = ax;
                n_stg.mw = bh;
                n_stg.mh = bw;
            end
            ROT_180: begin
                n_stg.mx = ww - ax - bw;
                n_stg.my = wh - ay - bh;
                n_stg.mw = bw;
                n_stg.mh = bh;
            end
            default: begin
                n_stg.mx = ay;
                n_stg.my = wh - ax - bw;
                n_stg.mw = bh;
                n_stg.mh = bw;
            end
        endcase

        // window test: a rectangle starting on the far edge, or with positive size ending on the near edge, fails
        v_neg  = (w > MW'(0) && xe <= MW'(0)) || (h > MW'(0) && ye <= MW'(0));
        v_edge = (x == ww) || (y == wh);
        xo     = (x >= MW'(0) && x <= ww) || (x <= MW'(0) && xe >= MW'(0));
        yo     = (y >= MW'(0) && y <= wh) || (y <= MW'(0) && ye >= MW'(0));
        n_stg.q_pass = !v_neg && !v_edge && xo && yo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_accept;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_req <= i_req;
        end
        if (r_vld1) begin
            r_stg <= n_stg;
        end
    end

    assign o_busy = r_vld1;
    assign o_vld  = r_vld2;
    assign o_stg  = r_stg;

endmodule

@@ src/crs_clip.sv @@
module crs_clip (
    input  crs_pkg::t_stage i_stg,
    input  logic            i_has_top,
    input  crs_pkg::t_scis  i_top,
    output crs_pkg::t_scis  o_scis
);
    import crs_pkg::*;

    localparam logic signed [CW-1:0] CMAX = CW'(2 ** (COORD_BITS - 1) - 1);
    localparam logic signed [CW-1:0] CMIN = CW'(-(2 ** (COORD_BITS - 1)));

    logic signed [CW-1:0] tx, ty, tw, th, te_x, te_y;
    logic signed [CW-1:0] nx, ny, ex, ey, nw, nh;

    always_comb begin
        tx   = CW'(i_top.x);
        ty   = CW'(i_top.y);
        tw   = CW'($signed({1'b0, i_top.w}));
        th   = CW'($signed({1'b0, i_top.h}));
        te_x = tx + tw;
        te_y = ty + th;

        nx = (i_has_top && tx > CW'(i_stg.mx)) ? tx : CW'(i_stg.mx);
        ny = (i_has_top && ty > CW'(i_stg.my)) ? ty : CW'(i_stg.my);
        ex = nx + CW'(i_stg.mw);
        ey = ny + CW'(i_stg.mh);
        nw = (i_has_top && te_x < ex) ? te_x - nx : CW'(i_stg.mw);
        nh = (i_has_top && te_y < ey) ? te_y - ny : CW'(i_stg.mh);

        // saturate to the stored coordinate range
        o_scis.x = (nx > CMAX) ? COORD_BITS'(CMAX) :
                   (nx < CMIN) ? COORD_BITS'(CMIN) : nx[COORD_BITS-1:0];
        o_scis.y = (ny > CMAX) ? COORD_BITS'(CMAX) :
                   (ny < CMIN) ? COORD_BITS'(CMIN) : ny[COORD_BITS-1:0];
        o_scis.w = (nw > CMAX)    ? CMAX[COORD_BITS-2:0] :
                   (nw < CW'(0)) ? '0 : nw[COORD_BITS-2:0];
        o_scis.h = (nh > CMAX)    ? CMAX[COORD_BITS-2:0] :
                   (nh < CW'(0)) ? '0 : nh[COORD_BITS-2:0];
    end

endmodule

@@ src/clip_rect_stack_engine.sv @@
// Channel   | Ports                              | Handshake
// ----------+------------------------------------+------------------------------------
// request   | i_req                              | taken when start high, busy low
// result    | o_rsp                              | o_valid high for one cycle, no stall
// config    | i_cfg_we, i_cfg_idx, i_cfg_wdata   | written when i_cfg_we high
//
// A request is mapped in the cycle after it is taken and merged with the stack top in
// the next; the merged result is registered into o_rsp with o_valid. busy is high in the
// cycle after acceptance, so a new request cannot be taken while the last is being mapped.
// The stack is a chain of cells with the top in cell 0; push and pop shift the chain.
// Reset clears the count, config and valids; stack contents are not cleared.
module clip_rect_stack_engine #(
    parameter int STACK_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  crs_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [14:0]   i_cfg_wdata,
    output logic          o_valid,
    output crs_pkg::t_rsp o_rsp
);
    import crs_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    t_cfg             r_cfg;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic   p1_busy, s_vld;
    t_stage s_stg;
    t_scis  clip_scis;
    t_shift shift;
    t_entry new_entry, second;
    t_entry cells [STACK_DEPTH];

    logic                 has_top, full, is_push, is_pop;
    logic signed [QW-1:0] nat_xe, nat_ye, rx, ry, nx, ny;
    logic                 nat_xo, nat_yo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIN_W: r_cfg.win_w <= i_cfg_wdata[13:0];
                CFG_WIN_H: r_cfg.win_h <= i_cfg_wdata[13:0];
                CFG_SCR_W: r_cfg.scr_w <= i_cfg_wdata[13:0];
                CFG_SCR_H: r_cfg.scr_h <= i_cfg_wdata[13:0];
                CFG_OFF_X: r_cfg.off_x <= i_cfg_wdata;
                CFG_OFF_Y: r_cfg.off_y <= i_cfg_wdata;
                CFG_ROT:   r_cfg.rot   <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign busy = p1_busy || !i_rst_n;

    crs_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start && !busy),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .o_busy   (p1_busy),
        .o_vld    (s_vld),
        .o_stg    (s_stg)
    );

    assign has_top = (r_count != '0);
    assign full    = (r_count == CNT_W'(STACK_DEPTH));
    assign is_push = s_vld && (s_stg.mode == MODE_PUSH) && !full;
    assign is_pop  = s_vld && (s_stg.mode == MODE_POP) && has_top;

    crs_clip u_clip (
        .i_stg     (s_stg),
        .i_has_top (has_top),
        .i_top     (cells[0].scis),
        .o_scis    (clip_scis)
    );

    assign new_entry = '{scis: clip_scis, nat: s_stg.nat};
    assign shift     = '{push: is_push, pop: is_pop};

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            t_entry above, below;
            if (g == 0) begin : g_first
                assign above = new_entry;
            end else begin : g_mid
                assign above = cells[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_last
                assign below = cells[g];
            end else begin : g_next
                assign below = cells[g+1];
            end
            crs_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (shift),
                .i_above (above),
                .i_below (below),
                .o_data  (cells[g])
            );
        end
        if (STACK_DEPTH > 1) begin : g_second
            assign second = cells[1];
        end else begin : g_single
            assign second = cells[0];
        end
    endgenerate

    // query against the top native clip
    always_comb begin
        rx     = QW'(s_stg.nat.x);
        ry     = QW'(s_stg.nat.y);
        nx     = QW'(cells[0].nat.x);
        ny     = QW'(cells[0].nat.y);
        nat_xe = nx + QW'(cells[0].nat.w);
        nat_ye = ny + QW'(cells[0].nat.h);
        nat_xo = (nx >= rx && nx <= s_stg.xe) || (rx >= nx && rx <= nat_xe);
        nat_yo = (ny >= ry && ny <= s_stg.ye) || (ry >= ny && ry <= nat_ye);
    end

    always_comb begin
        n_count = r_count;
        n_rsp   = '0;

        if (is_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (is_pop) begin
            n_count = r_count - CNT_W'(1);
        end

        priority if (s_stg.mode == MODE_PUSH && full) begin
            n_rsp.status = ST_FULL;
        end else if (s_stg.mode == MODE_POP && !has_top) begin
            n_rsp.status = ST_EMPTY;
        end else begin
            n_rsp.status = ST_OK;
        end

        priority if (is_push) begin
            n_rsp.scissor_on  = 1'b1;
            n_rsp.scissor_x   = clip_scis.x;
            n_rsp.scissor_y   = clip_scis.y;
            n_rsp.scissor_w   = clip_scis.w;
            n_rsp.scissor_h   = clip_scis.h;
        end else if (is_pop) begin
            if (r_count > CNT_W'(1)) begin
                n_rsp.scissor_on = 1'b1;
                n_rsp.scissor_x  = second.scis.x;
                n_rsp.scissor_y  = second.scis.y;
                n_rsp.scissor_w  = second.scis.w;
                n_rsp.scissor_h  = second.scis.h;
            end
        end else if (has_top) begin
            n_rsp.scissor_on = 1'b1;
            n_rsp.scissor_x  = cells[0].scis.x;
            n_rsp.scissor_y  = cells[0].scis.y;
            n_rsp.scissor_w  = cells[0].scis.w;
            n_rsp.scissor_h  = cells[0].scis.h;
        end
        n_rsp.clipping_on = n_rsp.scissor_on;

        n_rsp.visible = (s_stg.mode == MODE_QUERY) && s_stg.q_pass &&
                        (!has_top || (nat_xo && nat_yo));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= s_vld ? n_count : r_count;
            r_valid <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`include "clip_rect_stack_engine_assert.svh"

    `CRSE_AST_IMP(a_latency, i_clk, i_rst_n, o_valid, $past(start && !busy, 3))
    `CRSE_AST_NXT(a_busy_one, i_clk, i_rst_n, p1_busy, !p1_busy)
    `CRSE_AST_IMP(a_full_on, i_clk, i_rst_n, o_valid && o_rsp.status == ST_FULL, o_rsp.clipping_on && r_count == CNT_W'(STACK_DEPTH))
    `CRSE_AST_IMP(a_off_zero, i_clk, i_rst_n, o_valid && !o_rsp.scissor_on, o_rsp.scissor_x == '0 && o_rsp.scissor_w == '0 && r_count == '0)

endmodule

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    localparam int         DEPTH      = 16;
    localparam int         LIMIT      = 400000;
    localparam int         PHASES     = 8;
    localparam int         PHASE_REQS = 166;
    localparam longint     CMAX       = 32767;
    localparam longint     CMIN       = -32768;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_req        i_req       = '0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_idx   = '0;
    logic [14:0] i_cfg_wdata = '0;
    logic        o_valid;
    t_rsp        o_rsp;

    clip_rect_stack_engine #(.STACK_DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

    // shadow of the block: registers and both stacks
    t_cfg  cfg = '0;
    t_scis scis_stk[DEPTH];
    t_rect nat_stk[DEPTH];
    int    clip_depth = 0;

    t_req  req_pending[$];
    t_rsp  rsp_due[$];

    int n_queued  = 0;
    int n_taken   = 0;
    int n_checked = 0;
    int n_errors  = 0;
    int cycles    = 0;
    int n_push = 0, n_full = 0, n_pop = 0, n_empty = 0;
    int n_query = 0, n_seen = 0, n_spare = 0;

    bit req_taken = 1'b0;
    int gap_left  = 0;
    bit gaps_on   = 1'b1;

    always #5 i_clk = ~i_clk;

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // inclusive overlap, touching edges count
    function automatic bit touches(input longint ax, input longint ay, input longint aw,
                                   input longint ah, input longint bx, input longint by,
                                   input longint bw, input longint bh);
        bit xo, yo;
        xo = (ax >= bx && ax <= bx + bw) || (bx >= ax && bx <= ax + aw);
        yo = (ay >= by && ay <= by + bh) || (by >= ay && by <= ay + ah);
        return xo && yo;
    endfunction

    function automatic t_rsp apply_request(input t_req rq);
        t_rsp   rs;
        t_scis  top;
        t_rect  nat;
        bit     vis;
        longint rx, ry, rw, rh, bw, bh, mx, my, mw, mh, tx, ty, tw, th;
        longint ww, wh, sw, sh, ox, oy;
        rs = '0;
        vis = 1'b0;
        ww = cfg.win_w;
        wh = cfg.win_h;
        sw = cfg.scr_w;
        sh = cfg.scr_h;
        ox = $signed(cfg.off_x);
        oy = $signed(cfg.off_y);
        rx = $signed(rq.pos_x);
        ry = $signed(rq.pos_y);
        rw = $signed(rq.size_w);
        rh = $signed(rq.size_h);
        case (rq.mode)
            MODE_PUSH: begin
                n_push++;
                if (clip_depth >= DEPTH) begin
                    rs.status = ST_FULL;
                    n_full++;
                end else begin
                    bw = (rw == 0) ? sw - rx : rw;
                    bh = (rh == 0) ? sh - ry : rh;
                    case (cfg.rot)
                        ROT_0: begin
                            mx = ox + rx;
                            my = oy + ry;
                            mw = bw;
                            mh = bh;
                        end
                        ROT_90: begin
                            mx = ww - oy - ry - bh;
                            my = ox + rx;
                            mw = bh;
                            mh = bw;
                        end
                        ROT_180: begin
                            mx = ww - ox - rx - bw;
                            my = wh - oy - ry - bh;
                            mw = bw;
                            mh = bh;
                        end
                        default: begin
                            mx = oy + ry;
                            my = wh - ox - rx - bw;
                            mw = bh;
                            mh = bw;
                        end
                    endcase
                    if (clip_depth > 0) begin
                        top = scis_stk[clip_depth - 1];
                        tx = $signed(top.x);
                        ty = $signed(top.y);
                        tw = top.w;
                        th = top.h;
                        if (tx > mx) mx = tx;
                        if (ty > my) my = ty;
                        if (tx + tw < mx + mw) mw = tx + tw - mx;
                        if (ty + th < my + mh) mh = ty + th - my;
                    end
                    mx = sat(mx, CMIN, CMAX);
                    my = sat(my, CMIN, CMAX);
                    mw = sat(mw, 0, CMAX);
                    mh = sat(mh, 0, CMAX);
                    top.x = mx[15:0];
                    top.y = my[15:0];
                    top.w = mw[14:0];
                    top.h = mh[14:0];
                    scis_stk[clip_depth] = top;
                    nat.x = rq.pos_x;
                    nat.y = rq.pos_y;
                    nat.w = rq.size_w;
                    nat.h = rq.size_h;
                    nat_stk[clip_depth] = nat;
                    clip_depth++;
                end
            end
            MODE_POP: begin
                n_pop++;
                if (clip_depth == 0) begin
                    rs.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    clip_depth--;
                end
            end
            MODE_QUERY: begin
                n_query++;
                vis = 1'b1;
                if (rw > 0 && rx + rw <= 0) vis = 1'b0;
                if (rh > 0 && ry + rh <= 0) vis = 1'b0;
                if (rx == ww || ry == wh) vis = 1'b0;
                if (vis && !touches(rx, ry, rw, rh, 0, 0, ww, wh)) vis = 1'b0;
                if (vis && clip_depth > 0) begin
                    nat = nat_stk[clip_depth - 1];
                    vis = touches($signed(nat.x), $signed(nat.y), $signed(nat.w),
                                  $signed(nat.h), rx, ry, rw, rh);
                end
                if (vis) n_seen++;
            end
            default: n_spare++;
        endcase
        if (clip_depth > 0) begin
            top = scis_stk[clip_depth - 1];
            rs.scissor_on  = 1'b1;
            rs.scissor_x   = top.x;
            rs.scissor_y   = top.y;
            rs.scissor_w   = top.w;
            rs.scissor_h   = top.h;
            rs.clipping_on = 1'b1;
        end
        rs.visible = vis;
        return rs;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got_v,
                                   input logic signed [31:0] want_v);
        n_errors++;
        if (n_errors <= 100)
            $display("mismatch on result %0d: %s got %0d want %0d",
                     n_checked, what, got_v, want_v);
    endtask

    // request driver
    function automatic int pick_gap();
        int p;
        if (!gaps_on) return 0;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (start) gap_left = pick_gap();
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (req_pending.size() != 0) begin
                i_req <= req_pending.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_rsp want;
        req_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_valid) begin
                if (rsp_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding", o_rsp.status, 0);
                end else begin
                    want = rsp_due.pop_front();
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", o_rsp.status, want.status);
                    if (o_rsp.scissor_on !== want.scissor_on)
                        report_mismatch("scissor_on", o_rsp.scissor_on, want.scissor_on);
                    if (o_rsp.scissor_x !== want.scissor_x)
                        report_mismatch("scissor_x", o_rsp.scissor_x, want.scissor_x);
                    if (o_rsp.scissor_y !== want.scissor_y)
                        report_mismatch("scissor_y", o_rsp.scissor_y, want.scissor_y);
                    if (o_rsp.scissor_w !== want.scissor_w)
                        report_mismatch("scissor_w", o_rsp.scissor_w, want.scissor_w);
                    if (o_rsp.scissor_h !== want.scissor_h)
                        report_mismatch("scissor_h", o_rsp.scissor_h, want.scissor_h);
                    if (o_rsp.clipping_on !== want.clipping_on)
                        report_mismatch("clipping_on", o_rsp.clipping_on, want.clipping_on);
                    if (o_rsp.visible !== want.visible)
                        report_mismatch("visible", o_rsp.visible, want.visible);
                end
                n_checked++;
            end
            if (start && !busy) begin
                rsp_due.push_back(apply_request(i_req));
                n_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, rsp_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus
    function automatic longint rnd16();
        logic [15:0] b;
        b = 16'($urandom);
        return $signed(b);
    endfunction

    function automatic longint rnd_coord(input longint span);
        longint v;
        case ($urandom_range(0, 9))
            0: return rnd16();
            1: begin
                case ($urandom_range(0, 3))
                    0: return CMIN;
                    1: return CMAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: begin
                v = $urandom_range(0, span + 128);
                return v - 64;
            end
        endcase
    endfunction

    function automatic longint rnd_size(input longint span);
        longint v;
        case ($urandom_range(0, 9))
            0, 1: return 0;
            2: begin
                v = $urandom_range(1, 100);
                return -v;
            end
            3: return rnd16();
            4: return ($urandom_range(0, 1) == 0) ? CMAX : CMIN;
            default: begin
                v = $urandom_range(1, span / 2 + 16);
                return v;
            end
        endcase
    endfunction

    function automatic void queue_req(input logic [1:0] m, input longint x, input longint y,
                                      input longint w, input longint h);
        t_req rq;
        rq.mode   = m;
        rq.pos_x  = x[15:0];
        rq.pos_y  = y[15:0];
        rq.size_w = w[15:0];
        rq.size_h = h[15:0];
        req_pending.push_back(rq);
        n_queued++;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_WIN_W: cfg.win_w = val[13:0];
            CFG_WIN_H: cfg.win_h = val[13:0];
            CFG_SCR_W: cfg.scr_w = val[13:0];
            CFG_SCR_H: cfg.scr_h = val[13:0];
            CFG_OFF_X: cfg.off_x = val;
            CFG_OFF_Y: cfg.off_y = val;
            CFG_ROT:   cfg.rot   = val[1:0];
            default: ;
        endcase
    endtask

    task automatic write_cfg(input t_cfg c);
        write_reg(CFG_WIN_W, {1'b0, c.win_w});
        write_reg(CFG_WIN_H, {1'b0, c.win_h});
        write_reg(CFG_SCR_W, {1'b0, c.scr_w});
        write_reg(CFG_SCR_H, {1'b0, c.scr_h});
        write_reg(CFG_OFF_X, c.off_x);
        write_reg(CFG_OFF_Y, c.off_y);
        write_reg(CFG_ROT, {13'd0, c.rot});
    endtask

    // wait until every queued request has been taken and answered
    task automatic settle();
        while (req_pending.size() != 0 || n_taken != n_queued || rsp_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(input t_cfg c, input int reqs, input bit gaps);
        int     target, k, j;
        longint span, lx, ly, lw, lh, qw, qh, wx, wy;
        write_cfg(c);
        gaps_on = gaps;
        wx = cfg.win_w;
        wy = cfg.win_h;
        span = (cfg.scr_w > cfg.win_w) ? cfg.scr_w : cfg.win_w;
        if (span < 64) span = 64;
        target = n_queued + reqs;
        while (n_queued < target) begin
            qw = $urandom_range(1, 8);
            qh = $urandom_range(1, 8);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // nested clips, often with a probe on the edge just pushed
                    k = $urandom_range(1, 20);
                    for (j = 0; j < k; j++) begin
                        lx = rnd_coord(span);
                        ly = rnd_coord(span);
                        lw = rnd_size(span);
                        lh = rnd_size(span);
                        queue_req(MODE_PUSH, lx, ly, lw, lh);
                        if (lw > 0 && lh > 0 && $urandom_range(0, 2) == 0) begin
                            case ($urandom_range(0, 3))
                                0: queue_req(MODE_QUERY, lx + lw, ly, qw, qh);
                                1: queue_req(MODE_QUERY, lx + lw + 1, ly, qw, qh);
                                2: queue_req(MODE_QUERY, lx - qw, ly + lh, qw, qh);
                                default: queue_req(MODE_QUERY, lx, ly + lh + 1, qw, qh);
                            endcase
                        end
                    end
                    k = $urandom_range(0, k + 2);
                    for (j = 0; j < k; j++)
                        queue_req(MODE_POP, rnd16(), rnd16(), rnd16(), rnd16());
                end
                5, 6: begin
                    case ($urandom_range(0, 5))
                        0: queue_req(MODE_QUERY, wx, rnd_coord(span), qw, qh);
                        1: queue_req(MODE_QUERY, wx - 1, rnd_coord(span), qw, qh);
                        2: queue_req(MODE_QUERY, -qw, rnd_coord(span), qw, qh);
                        3: queue_req(MODE_QUERY, 1 - qw, rnd_coord(span), qw, qh);
                        4: queue_req(MODE_QUERY, rnd_coord(span), wy, qw, qh);
                        default: queue_req(MODE_QUERY, rnd_coord(span), rnd_coord(span),
                                           rnd_size(span), rnd_size(span));
                    endcase
                end
                7: begin
                    k = $urandom_range(1, 4);
                    for (j = 0; j < k; j++)
                        queue_req(MODE_POP, rnd_coord(span), 0, 0, 0);
                end
                default: queue_req(2'($urandom), rnd16(), rnd16(), rnd16(), rnd16());
            endcase
        end
        settle();
    endtask

    initial begin
        t_cfg c;
        int   p;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        c = '0;
        c.win_w = 14'd640;
        c.win_h = 14'd480;
        c.scr_w = 14'd640;
        c.scr_h = 14'd480;
        c.rot   = ROT_0;
        write_cfg(c);

        // directed: empty stack, window edges, clamp, saturation, underflow
        queue_req(MODE_POP, 0, 0, 0, 0);
        queue_req(MODE_QUERY, 10, 10, 5, 5);
        queue_req(MODE_QUERY, 640, 10, 5, 5);
        queue_req(MODE_QUERY, -5, 10, 5, 5);
        queue_req(MODE_SPARE, 1, 2, 3, 4);
        queue_req(MODE_PUSH, 0, 0, 0, 0);
        queue_req(MODE_PUSH, 100, 50, 200, 100);
        queue_req(MODE_QUERY, 300, 60, 10, 10);
        queue_req(MODE_QUERY, 301, 60, 10, 10);
        queue_req(MODE_PUSH, 120, 60, -10, -20);
        queue_req(MODE_POP, 0, 0, 0, 0);
        queue_req(MODE_PUSH, CMAX, CMIN, CMAX, CMAX);
        queue_req(MODE_PUSH, CMIN, CMAX, CMIN, CMIN);
        queue_req(MODE_PUSH, CMAX, CMAX, 0, 0);
        for (p = 0; p < 6; p++)
            queue_req(MODE_POP, 0, 0, 0, 0);
        queue_req(MODE_QUERY, CMIN, CMIN, -1, -1);
        settle();

        for (p = 0; p < PHASES; p++) begin
            c = '0;
            case (p)
                0: begin
                    c.win_w = 14'd640;
                    c.win_h = 14'd480;
                    c.scr_w = 14'd640;
                    c.scr_h = 14'd480;
                    c.rot   = ROT_0;
                end
                1: begin
                    c.win_w = 14'd480;
                    c.win_h = 14'd640;
                    c.scr_w = 14'd640;
                    c.scr_h = 14'd480;
                    c.off_x = 15'sd8;
                    c.off_y = -15'sd4;
                    c.rot   = ROT_90;
                end
                2: begin
                    c.win_w = 14'd640;
                    c.win_h = 14'd480;
                    c.scr_w = 14'd600;
                    c.scr_h = 14'd400;
                    c.off_x = -15'sd20;
                    c.off_y = 15'sd30;
                    c.rot   = ROT_180;
                end
                3: begin
                    c.win_w = 14'd480;
                    c.win_h = 14'd640;
                    c.scr_w = 14'd640;
                    c.scr_h = 14'd480;
                    c.rot   = ROT_270;
                end
                4: begin
                    c.win_w = 14'h3fff;
                    c.win_h = 14'h3fff;
                    c.scr_w = 14'h3fff;
                    c.scr_h = 14'h3fff;
                    c.off_x = 15'sh3fff;
                    c.off_y = 15'sh3fff;
                    c.rot   = 2'($urandom);
                end
                5: begin
                    // empty window, most negative offsets
                    c.off_x = 15'h4000;
                    c.off_y = 15'h4000;
                    c.rot   = 2'($urandom);
                end
                default: begin
                    c.win_w = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(1, 2000))
                                                         : 14'($urandom);
                    c.win_h = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(1, 2000))
                                                         : 14'($urandom);
                    c.scr_w = 14'($urandom);
                    c.scr_h = 14'($urandom_range(1, 2000));
                    c.off_x = 15'($urandom);
                    c.off_y = 15'($urandom);
                    c.rot   = 2'($urandom);
                end
            endcase
            run_phase(c, PHASE_REQS, (p % 3) != 2);
        end

        $display("%0d requests over %0d register settings: %0d pushes (%0d on a full stack),",
                 n_taken, PHASES + 1, n_push, n_full);
        $display("%0d pops (%0d on empty), %0d queries (%0d visible), %0d spare; %0d results",
                 n_pop, n_empty, n_query, n_seen, n_spare, n_checked);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/crs_pkg.sv
src/crs_cell.sv
src/crs_map.sv
src/crs_clip.sv
src/clip_rect_stack_engine.sv
bench/testbench.sv
